### rtl/grid_min_path_sum_assert.svh
// Assertion macros for the grid_min_path_sum block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef GRID_MIN_PATH_SUM_ASSERT_SVH
`define GRID_MIN_PATH_SUM_ASSERT_SVH
`ifndef SYNTH
`define GMPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gmps assertion failed");
`define GMPS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("gmps forbidden condition");
`else
`define GMPS_ASSERT(lbl, clk, rstn, prop)
`define GMPS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### rtl/gmps_pkg.sv
// Shared constants, types and helpers for the grid minimum path sum block.
// No dependencies.
package gmps_pkg;

  localparam int unsigned INDEX_LIMIT     = 256;
  localparam int unsigned CNT_W           = 9;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned SUM_W           = 32;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned DEF_MAX_COLUMNS = 256;
  localparam int unsigned DEF_MAX_ROWS    = 256;
  localparam int unsigned DEF_COST_BITS   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
  } result_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/grid_min_path_sum.sv
// Minimum right/down path sum over a streamed cost grid. Cells arrive in raster
// order, one per transfer, and each yields its best path sum in the next cycle;
// the flag marks the final cell, whose sum is the grid answer. The block takes one
// cell per cycle unless stalled: the single min/add/saturate stage sets the rate;
// the row above sits in a chain of MAX_COLUMNS sum cells (up to 256) that shifts
// on every transfer, so the sum above is always at the chain's far end. Writing
// row_count or column_count restarts the sweep; no clearing pass follows reset.
// Depends on gmps_pkg, gmps_cell, gmps_core and grid_min_path_sum_assert.svh.
`include "grid_min_path_sum_assert.svh"

module grid_min_path_sum #(
  parameter int unsigned MAX_COLUMNS = gmps_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = gmps_pkg::DEF_MAX_ROWS,
  parameter int unsigned COST_BITS   = gmps_pkg::DEF_COST_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gmps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gmps_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [COST_BITS-1:0]           cell_cost_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gmps_pkg::SUM_W-1:0]     path_sum_o,
  output logic                           is_last_o
);

  localparam int unsigned DEPTH = (MAX_COLUMNS < gmps_pkg::INDEX_LIMIT) ? MAX_COLUMNS
                                                                       : gmps_pkg::INDEX_LIMIT;
  localparam int unsigned ROW_LIM = (MAX_ROWS < gmps_pkg::INDEX_LIMIT) ? MAX_ROWS
                                                                      : gmps_pkg::INDEX_LIMIT;
  localparam int unsigned POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [gmps_pkg::CNT_W-1:0] row_count_q, row_count_d;
  logic [gmps_pkg::CNT_W-1:0] column_count_q, column_count_d;
  logic                       restart;
  logic                       accept;

  logic                       out_valid_q;
  logic [gmps_pkg::SUM_W-1:0] path_sum_q;
  logic                       is_last_q;

  gmps_pkg::result_t          res;
  logic [gmps_pkg::SUM_W-1:0] cost_ext;
  logic [gmps_pkg::SUM_W-1:0] line [DEPTH];
  logic [gmps_pkg::CNT_W-1:0] ins_full;
  logic [POS_W-1:0]           ins_pos;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign restart     = cfg_valid_i &&
                       (cfg_index_i == gmps_pkg::REG_ROW_COUNT ||
                        cfg_index_i == gmps_pkg::REG_COLUMN_COUNT);

  always_comb begin
    row_count_d    = row_count_q;
    column_count_d = column_count_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        gmps_pkg::REG_ROW_COUNT: begin
          row_count_d = gmps_pkg::clamp_count(cfg_data_i, gmps_pkg::CNT_W'(ROW_LIM));
        end
        gmps_pkg::REG_COLUMN_COUNT: begin
          column_count_d = gmps_pkg::clamp_count(cfg_data_i, gmps_pkg::CNT_W'(DEPTH));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= gmps_pkg::CNT_W'(1);
      column_count_q <= gmps_pkg::CNT_W'(1);
    end else begin
      row_count_q    <= row_count_d;
      column_count_q <= column_count_d;
    end
  end

  // input side
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cost_ext   = gmps_pkg::SUM_W'(cell_cost_i);

  gmps_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .restart_i      (restart),
    .cost_i         (cost_ext),
    .above_i        (line[DEPTH-1]),
    .row_count_i    (row_count_q),
    .column_count_i (column_count_q),
    .res_o          (res)
  );

  // new sums enter column_count cells before the end of the chain
  assign ins_full = gmps_pkg::CNT_W'(DEPTH) - column_count_q;
  assign ins_pos  = ins_full[POS_W-1:0];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [gmps_pkg::SUM_W-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = res.sum;
    end else begin : g_body
      assign prev = line[k-1];
    end
    gmps_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (accept),
      .load_i  (ins_pos == POS_W'(k)),
      .new_i   (res.sum),
      .prev_i  (prev),
      .sum_o   (line[k])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      path_sum_q <= res.sum;
      is_last_q  <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_sum_o  = path_sum_q;
  assign is_last_o   = is_last_q;

  `GMPS_ASSERT(a_accept_shows, clk_i, rst_ni,
               accept |=> out_valid_q && path_sum_q == $past(res.sum))
  `GMPS_ASSERT_NEVER(a_col_count_range, clk_i, rst_ni,
                     column_count_q == '0 || column_count_q > gmps_pkg::CNT_W'(DEPTH))

endmodule

### rtl/gmps_cell.sv
// One cell of the row-sum chain: holds the best sum of one column of the previous row.
// Depends on gmps_pkg.
module gmps_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic                       load_i,
  input  logic [gmps_pkg::SUM_W-1:0] new_i,
  input  logic [gmps_pkg::SUM_W-1:0] prev_i,
  output logic [gmps_pkg::SUM_W-1:0] sum_o
);

  logic [gmps_pkg::SUM_W-1:0] sum_q;
  logic [gmps_pkg::SUM_W-1:0] sum_d;

  // load marks the entry point of the chain for the current row length
  assign sum_d = load_i ? new_i : prev_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### rtl/gmps_core.sv
// Per-cell datapath: position counters, left sum, min/add/saturate.
// Depends on gmps_pkg and grid_min_path_sum_assert.svh.
`include "grid_min_path_sum_assert.svh"

module gmps_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       restart_i,
  input  logic [gmps_pkg::SUM_W-1:0] cost_i,
  input  logic [gmps_pkg::SUM_W-1:0] above_i,
  input  logic [gmps_pkg::CNT_W-1:0] row_count_i,
  input  logic [gmps_pkg::CNT_W-1:0] column_count_i,
  output gmps_pkg::result_t          res_o
);

  logic [gmps_pkg::IDX_W-1:0] row_q, row_d;
  logic [gmps_pkg::IDX_W-1:0] col_q, col_d;
  logic [gmps_pkg::SUM_W-1:0] left_q, left_d;

  logic                       have_above, have_left;
  logic [gmps_pkg::SUM_W-1:0] best;
  logic [gmps_pkg::SUM_W:0]   sum_wide;
  logic [gmps_pkg::SUM_W-1:0] sum;
  logic [gmps_pkg::CNT_W-1:0] row_next, col_next;
  logic                       row_end, col_end;

  assign have_above = (row_q != '0);
  assign have_left  = (col_q != '0);

  always_comb begin
    if (have_above && have_left) begin
      best = (above_i < left_q) ? above_i : left_q;
    end else if (have_above) begin
      best = above_i;
    end else if (have_left) begin
      best = left_q;
    end else begin
      best = '0;
    end
  end

  assign sum_wide = {1'b0, cost_i} + {1'b0, best};
  assign sum      = sum_wide[gmps_pkg::SUM_W] ? gmps_pkg::SUM_MAX
                                              : sum_wide[gmps_pkg::SUM_W-1:0];

  assign row_next = {1'b0, row_q} + gmps_pkg::CNT_W'(1);
  assign col_next = {1'b0, col_q} + gmps_pkg::CNT_W'(1);
  assign row_end  = (row_next >= row_count_i);
  assign col_end  = (col_next >= column_count_i);

  assign res_o.sum  = sum;
  assign res_o.last = row_end && col_end;

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    left_d = left_q;
    if (restart_i) begin
      row_d  = '0;
      col_d  = '0;
      left_d = '0;
    end else if (accept_i) begin
      left_d = sum;
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_next[gmps_pkg::IDX_W-1:0];
      end else begin
        col_d = col_next[gmps_pkg::IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      left_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      left_q <= left_d;
    end
  end

  `GMPS_ASSERT(a_wrap_on_last, clk_i, rst_ni,
               accept_i && !restart_i && res_o.last |=> row_q == '0 && col_q == '0)
  `GMPS_ASSERT_NEVER(a_col_in_range, clk_i, rst_ni, gmps_pkg::CNT_W'(col_q) >= column_count_i)
  `GMPS_ASSERT_NEVER(a_sum_below_cost, clk_i, rst_ni, sum < cost_i)

endmodule
